// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Request and status codes, cell operations and sizes of the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH   = 128;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 8;
  localparam int unsigned POP_W   = 32;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell of the row does on an update
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_IN,   // push front: every cell takes its left neighbor
    OP_APPEND,     // push back: first empty cell takes the word
    OP_SHIFT_OUT,  // pop front: every cell takes its right neighbor
    OP_DROP_BACK   // pop back: last full cell empties
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [WORD_W-1:0]   word;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: fixed-depth deque built as a row of shifting cells
// Push or pop words at either end; one result word per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request type
//   (push front, push back, pop front, pop back), tdata the word to push.
//   Every accepted request yields exactly one result word on m_axis:
//   tdata holds the popped word (zero for pushes and failed pops) and the
//   occupancy after the request, tuser holds the status (ok, pop on empty,
//   push on full). A push into a full queue is dropped.
//   m_axis_tvalid rises in the cycle after acceptance. While the receiver
//   does not stall, one request is taken every cycle: the row of DEPTH
//   cells updates together, each cell taking a neighbor's word on front
//   operations; the pop-back word comes from the one last full cell.
//   The result sits in an output register; while the receiver stalls the
//   register holds and s_axis_tready drops, and a new request is taken in
//   the same cycle the pending result is taken.
//   Reset empties the queue at once (all cell full flags and the count
//   clear); no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] push_word
  input  wire logic [REQ_W-1:0]      s_axis_tuser,   // [1:0] req_type
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] pop_word, [39:32] occupancy
  output logic      [STAT_W-1:0]     m_axis_tuser    // [1:0] status
);

  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [WORD_W-1:0] cell_tail [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [WORD_W-1:0] back_word;

  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q;
  logic [POP_W-1:0]   pop_q, pop_d;
  status_e            status_q, status_d;
  logic [OCC_W-1:0]   occ_q;

  logic       accept;
  req_e       req;
  cell_op_e   op;
  cell_ctrl_t ctrl;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = req_e'(s_axis_tuser);

  // ---------------- cell row ----------------
  assign ctrl.op   = accept ? op : OP_HOLD;
  assign ctrl.word = s_axis_tdata[WORD_W-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] prev_data, next_data;
    logic              prev_valid, next_valid;

    if (i == 0) begin : g_head
      assign prev_data  = s_axis_tdata[WORD_W-1:0];
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_data  = cell_data[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_data  = '0;
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_data  = cell_data[i+1];
      assign next_valid = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_data_i  (prev_data),
      .prev_valid_i (prev_valid),
      .next_data_i  (next_data),
      .next_valid_i (next_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i]),
      .tail_data_o  (cell_tail[i])
    );
  end

  // only the last full cell drives a nonzero word
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tail[i];
    end
  end

  // ---------------- request decode ----------------
  always_comb begin
    op       = OP_HOLD;
    status_d = ST_OK;
    pop_d    = '0;
    count_d  = count_q;
    unique case (req) inside
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (count_q == COUNT_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          op      = (req == REQ_PUSH_FRONT) ? OP_SHIFT_IN : OP_APPEND;
          count_d = count_q + COUNT_W'(1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          op      = (req == REQ_POP_FRONT) ? OP_SHIFT_OUT : OP_DROP_BACK;
          pop_d   = (req == REQ_POP_FRONT) ? POP_W'(cell_data[0]) : POP_W'(back_word);
          count_d = count_q - COUNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- state and output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (s_axis_tready) begin
        out_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_q    <= pop_d;
      status_q <= status_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {occ_q, pop_q};
  assign m_axis_tuser  = status_q;

  // ---------------- assertions ----------------
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(count_q))
    else $error("count differs from number of full cells");

  a_cells_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("full cells are not a prefix of the row");

  a_full_status_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d == ST_FULL) |=> (occ_q == OCC_W'(DEPTH)))
    else $error("full status with queue not full");

  a_empty_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d == ST_EMPTY) |=> (occ_q == '0 && pop_q == '0))
    else $error("empty status with nonzero occupancy or word");

endmodule

`default_nettype wire

// ===== rtl/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell: one slot of the queue's cell row
// Holds one word and a full flag; shifts with its neighbors on front
// operations and fills or empties itself at the back edge of the row.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell
  import deq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic [WORD_W-1:0] prev_data_i,
  input  wire logic              prev_valid_i,
  input  wire logic [WORD_W-1:0] next_data_i,
  input  wire logic              next_valid_i,
  output logic      [WORD_W-1:0] data_o,
  output logic                   valid_o,
  output logic      [WORD_W-1:0] tail_data_o
);

  logic [WORD_W-1:0] data_q, data_d;
  logic              valid_q, valid_d;
  logic              is_tail;

  // last full cell of the row
  assign is_tail = valid_q && !next_valid_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      OP_SHIFT_IN: begin
        data_d  = prev_data_i;
        valid_d = prev_valid_i;
      end
      OP_APPEND: begin
        if (!valid_q && prev_valid_i) begin
          data_d  = ctrl_i.word;
          valid_d = 1'b1;
        end
      end
      OP_SHIFT_OUT: begin
        data_d  = next_data_i;
        valid_d = next_valid_i;
      end
      OP_DROP_BACK: begin
        if (is_tail) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign valid_o     = valid_q;
  assign tail_data_o = is_tail ? data_q : '0;

endmodule

`default_nettype wire

// ===== test/double_ended_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test: self-checking bench for the double-ended queue
// Drives push/pop requests on either end with bursty input and a stalling
// receiver. A ring-buffer mirror of the queue predicts each result word,
// which is checked field by field against the block's output.
// ----------------------------------------------------------------------------

module double_ended_queue_test
  import deq_pkg::*;
();

  typedef struct {
    logic [POP_W-1:0] pop_word;
    status_e          status;
    logic [OCC_W-1:0] occupancy;
  } deq_result_t;

  // Ring-buffer copy of the queue plus the results it still owes
  class deque_mirror;
    logic [WORD_W-1:0] ring [DEPTH];
    int unsigned       head;
    int unsigned       held;
    int unsigned       accepted_count;
    int unsigned       mismatches;
    deq_result_t       owed_results [$];

    function new();
      head           = 0;
      held           = 0;
      accepted_count = 0;
      mismatches     = 0;
    endfunction

    function int unsigned owed_count();
      return owed_results.size();
    endfunction

    function void apply_request(req_e kind, logic [IN_DATA_W-1:0] word);
      deq_result_t res;
      res.pop_word = '0;
      res.status   = ST_OK;
      accepted_count++;
      case (kind) inside
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (held >= DEPTH) begin
            res.status = ST_FULL;
          end else if (kind == REQ_PUSH_FRONT) begin
            head       = (head + DEPTH - 1) % DEPTH;
            ring[head] = word[WORD_W-1:0];
            held++;
          end else begin
            ring[(head + held) % DEPTH] = word[WORD_W-1:0];
            held++;
          end
        end
        default: begin
          if (held == 0) begin
            res.status = ST_EMPTY;
          end else if (kind == REQ_POP_FRONT) begin
            res.pop_word = POP_W'(ring[head]);
            head         = (head + 1) % DEPTH;
            held--;
          end else begin
            res.pop_word = POP_W'(ring[(head + held - 1) % DEPTH]);
            held--;
          end
        end
      endcase
      res.occupancy = OCC_W'(held);
      owed_results.push_back(res);
    endfunction

    function void check_result(logic [POP_W-1:0] pop_word, logic [STAT_W-1:0] status,
                               logic [OCC_W-1:0] occupancy);
      deq_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t ERROR: unexpected word pop=%h status=%0d occ=%0d",
                 $time, pop_word, status, occupancy);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (pop_word !== want.pop_word) begin
        $display("%0t ERROR: pop_word expected %h actual %h", $time, want.pop_word, pop_word);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t ERROR: status expected %0d actual %0d", $time, want.status, status);
        mismatches++;
      end
      if (occupancy !== want.occupancy) begin
        $display("%0t ERROR: occupancy expected %0d actual %0d",
                 $time, want.occupancy, occupancy);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]     m_axis_tuser;

  deque_mirror mirror;
  bit          long_hold_done = 1'b0;

  double_ended_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Both handshakes observed at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        mirror.apply_request(req_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        mirror.check_result(m_axis_tdata[POP_W-1:0], m_axis_tuser,
                            m_axis_tdata[POP_W +: OCC_W]);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_request(input req_e kind, input logic [IN_DATA_W-1:0] word);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_input(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= REQ_W'($urandom);
    s_axis_tdata  <= $urandom;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (mirror.owed_count() != 0) @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned push_pct);
    logic [IN_DATA_W-1:0] word;
    req_e                 kind;
    case ($urandom_range(0, 7))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    if ($urandom_range(0, 99) < push_pct)
      kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    else
      kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
    send_request(kind, word);
  endtask

  // Receiver: switches among always-ready, random and patterned stall modes, plus one long hold-off
  initial begin : receiver
    int unsigned cycle;
    int unsigned mode;
    int unsigned hold_left;
    cycle     = 0;
    mode      = 0;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && mirror.accepted_count >= 700) begin
        long_hold_done = 1'b1;
        hold_left      = 300;
        m_axis_tready <= 1'b0;
      end else begin
        if (cycle % 64 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ((cycle % 8) < 5);
        endcase
      end
      cycle++;
    end
  end

  initial begin : stimulus
    int unsigned push_pct;
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    mirror = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty pops, extreme words, both ends, drain back to empty
    send_request(REQ_POP_FRONT,  32'h1234_5678);
    send_request(REQ_POP_BACK,   32'hFFFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK,  32'h0000_0000);
    send_request(REQ_PUSH_FRONT, 32'h0000_0000);
    send_request(REQ_PUSH_BACK,  32'hFFFF_FFFF);
    send_request(REQ_PUSH_FRONT, 32'hA5A5_A5A5);
    send_request(REQ_PUSH_BACK,  32'h5A5A_5A5A);
    send_request(REQ_POP_FRONT,  32'hFFFF_FFFF);
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_POP_FRONT,  32'h0000_0000);
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_POP_FRONT,  32'h0000_0000);
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_PUSH_BACK,  32'h0000_0001);
    send_request(REQ_POP_FRONT,  32'h0000_0000);
    send_request(REQ_PUSH_FRONT, 32'h8000_0000);
    send_request(REQ_POP_BACK,   32'h0000_0000);
    send_request(REQ_POP_FRONT,  32'h0000_0000);
    wait_drained();

    // Random: alternate fill-heavy, drain-heavy and mixed phases
    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0:       push_pct = 90;
        1:       push_pct = 10;
        2:       push_pct = 50;
        default: push_pct = $urandom_range(20, 80);
      endcase
      sent = 0;
      while (sent < 250) begin
        burst = $urandom_range(1, 32);
        for (int i = 0; i < burst && sent < 250; i++) begin
          send_random(push_pct);
          sent++;
        end
        gap = (seg == 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) idle_input(gap);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.owed_count() == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("double_ended_queue verification failed");
    $finish;
  end

endmodule
